// File: design/umidi_pkg.sv
// Shared types, constants and helpers for the USB MIDI packet ring engine.
// Used by usb_midi_packet_fifo_engine; depends on nothing.
`default_nettype none

package umidi_pkg;

    // Ring geometry
    localparam int TX_DEPTH     = 256;
    localparam int RX_DEPTH     = 256;
    localparam int PACKET_WORDS = 16;

    localparam int TX_AW = $clog2(TX_DEPTH);
    localparam int RX_AW = $clog2(RX_DEPTH);
    localparam int CNT_W = $clog2(PACKET_WORDS + 1);
    localparam int SUM_W = ((RX_AW > 5) ? RX_AW : 5) + 1;
    localparam int CMP_W = TX_AW + CNT_W;

    // Field widths
    localparam int ACTION_W   = 3;
    localparam int PKG_W      = 32;
    localparam int BW_W       = 5;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 3;
    localparam int LEVEL_W    = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_CONN    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_PUSH    = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_POP     = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_SERVICE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DONE    = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_RXWORD  = 3'd5;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WORD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_CONN = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NO_ROOM  = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEV_CFG     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT = 1'd1;

    localparam logic [CFG_DATA_W-1:0] BATCH_LIMIT_RST = 5'd16;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic                connected;
        logic [PKG_W-1:0]    package_req;
        logic [BW_W-1:0]     batch_words;
        logic                first_of_batch;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [PKG_W-1:0]    data;
        logic [STATUS_W-1:0] status;
        logic [LEVEL_W-1:0]  level;
        logic                last;
    } result_t;

    function automatic logic [TX_AW-1:0] tx_ptr_inc(input logic [TX_AW-1:0] p);
        return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
    endfunction

    function automatic logic [RX_AW-1:0] rx_ptr_inc(input logic [RX_AW-1:0] p);
        return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
    endfunction

endpackage

`default_nettype wire

// File: design/umidi_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read that holds its data while no read is issued. No dependencies.
`default_nettype none

module umidi_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: design/usb_midi_packet_fifo_engine.sv
// USB MIDI device-side packet ring engine: transmit and receive rings of
// 32-bit event packages. Depends on umidi_pkg and umidi_ram.
`default_nettype none

// One item is handled at a time. Set connection, receive word, pop and a push
// that starts no drain are accepted, then give their one result; the receive
// RAM read issued at the accept edge is ready in S_POP. A drain sends each word
// by a transmit RAM read in S_DRD, then a load of the result register in S_DWAIT,
// which waits while the result register is held. The result register frees the
// input side: the next item is taken while the last result waits.
// Results of an item come in order: sent words with last low, then one status
// or popped-package result with last high.
module usb_midi_packet_fifo_engine (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   item_valid,
    output      logic                                   item_stall,
    input  wire umidi_pkg::item_t                       item,
    output      logic                                   result_valid,
    input  wire logic                                   result_stall,
    output      umidi_pkg::result_t                     result,
    input  wire logic                                   cfg_we,
    input  wire logic [umidi_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [umidi_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DRD   = 3'd1;
    localparam logic [2:0] S_DWAIT = 3'd2;
    localparam logic [2:0] S_POP   = 3'd3;
    localparam logic [2:0] S_STAT  = 3'd4;

    logic [2:0]                          state_reg, state_next;
    logic [umidi_pkg::TX_AW-1:0]         tx_head_reg, tx_head_next;
    logic [umidi_pkg::TX_AW-1:0]         tx_tail_reg, tx_tail_next;
    logic [umidi_pkg::TX_AW-1:0]         tx_level_reg, tx_level_next;
    logic [umidi_pkg::RX_AW-1:0]         rx_head_reg, rx_head_next;
    logic [umidi_pkg::RX_AW-1:0]         rx_tail_reg, rx_tail_next;
    logic [umidi_pkg::RX_AW-1:0]         rx_level_reg, rx_level_next;
    logic                                link_up_reg, link_up_next;
    logic                                tx_busy_reg, tx_busy_next;
    logic                                rx_batch_ok_reg, rx_batch_ok_next;
    logic [umidi_pkg::CNT_W-1:0]         rx_left_reg, rx_left_next;
    logic [umidi_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [umidi_pkg::STATUS_W-1:0]      st_reg, st_next;
    logic                                dev_cfg_reg;
    logic [umidi_pkg::CFG_DATA_W-1:0]    batch_limit_reg;
    logic                                result_valid_reg, result_valid_next;
    umidi_pkg::result_t                  result_reg, result_next;

    logic                                take;
    logic                                out_free;
    logic                                load_res;
    logic [umidi_pkg::CNT_W-1:0]         lim;
    logic [umidi_pkg::CNT_W-1:0]         n_drain;
    logic                                tx_ready_drain;
    logic                                rx_open;
    logic                                rx_ok;
    logic [umidi_pkg::CNT_W-1:0]         rx_left_cur;

    logic                                tx_we, tx_re;
    logic [umidi_pkg::TX_AW-1:0]         tx_raddr;
    logic [umidi_pkg::PKG_W-1:0]         tx_rdata;
    logic                                rx_we, rx_re;
    logic [umidi_pkg::PKG_W-1:0]         rx_rdata;

    umidi_ram #(
        .DEPTH (umidi_pkg::TX_DEPTH),
        .WIDTH (umidi_pkg::PKG_W)
    ) u_tx_ram (
        .clk   (clk),
        .we    (tx_we),
        .waddr (tx_head_reg),
        .wdata (item.package_req),
        .re    (tx_re),
        .raddr (tx_raddr),
        .rdata (tx_rdata)
    );

    umidi_ram #(
        .DEPTH (umidi_pkg::RX_DEPTH),
        .WIDTH (umidi_pkg::PKG_W)
    ) u_rx_ram (
        .clk   (clk),
        .we    (rx_we),
        .waddr (rx_head_reg),
        .wdata (item.package_req),
        .re    (rx_re),
        .raddr (rx_tail_reg),
        .rdata (rx_rdata)
    );

    assign take       = item_valid && (state_reg == S_IDLE);
    assign item_stall = (state_reg != S_IDLE);
    assign out_free   = !result_valid_reg || !result_stall;
    assign tx_raddr   = tx_tail_reg;

    // Saturate the batch limit to 1..PACKET_WORDS, then clip to the ring level
    always_comb
    begin
        if (batch_limit_reg == '0)
        begin
            lim = umidi_pkg::CNT_W'(1);
        end
        else if (batch_limit_reg > umidi_pkg::CFG_DATA_W'(umidi_pkg::PACKET_WORDS))
        begin
            lim = umidi_pkg::CNT_W'(umidi_pkg::PACKET_WORDS);
        end
        else
        begin
            lim = umidi_pkg::CNT_W'(batch_limit_reg);
        end
        if (umidi_pkg::CMP_W'(tx_level_reg) < umidi_pkg::CMP_W'(lim))
        begin
            n_drain = umidi_pkg::CNT_W'(tx_level_reg);
        end
        else
        begin
            n_drain = lim;
        end
    end

    assign tx_ready_drain = (tx_level_reg != '0) && link_up_reg && dev_cfg_reg;

    // A receive packet opens only if the whole batch fits (strict less-than)
    assign rx_open = dev_cfg_reg
                     && (item.batch_words != '0)
                     && (item.batch_words <= umidi_pkg::BW_W'(umidi_pkg::PACKET_WORDS))
                     && ((umidi_pkg::SUM_W'(rx_level_reg) + umidi_pkg::SUM_W'(item.batch_words))
                         < umidi_pkg::SUM_W'(umidi_pkg::RX_DEPTH));
    assign rx_ok       = item.first_of_batch ? rx_open : rx_batch_ok_reg;
    assign rx_left_cur = item.first_of_batch
                         ? (rx_open ? umidi_pkg::CNT_W'(item.batch_words) : '0)
                         : rx_left_reg;

    always_comb
    begin
        state_next        = state_reg;
        tx_head_next      = tx_head_reg;
        tx_tail_next      = tx_tail_reg;
        tx_level_next     = tx_level_reg;
        rx_head_next      = rx_head_reg;
        rx_tail_next      = rx_tail_reg;
        rx_level_next     = rx_level_reg;
        link_up_next      = link_up_reg;
        tx_busy_next      = tx_busy_reg;
        rx_batch_ok_next  = rx_batch_ok_reg;
        rx_left_next      = rx_left_reg;
        cnt_next          = cnt_reg;
        st_next           = st_reg;
        tx_we             = 1'b0;
        tx_re             = 1'b0;
        rx_we             = 1'b0;
        rx_re             = 1'b0;
        load_res          = 1'b0;
        result_next       = result_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    st_next    = umidi_pkg::ST_OK;
                    state_next = S_STAT;
                    case (item.action)
                        umidi_pkg::ACT_CONN:
                        begin
                            tx_head_next     = '0;
                            tx_tail_next     = '0;
                            tx_level_next    = '0;
                            rx_head_next     = '0;
                            rx_tail_next     = '0;
                            rx_level_next    = '0;
                            rx_batch_ok_next = 1'b0;
                            rx_left_next     = '0;
                            link_up_next     = item.connected;
                            tx_busy_next     = !item.connected;
                        end
                        umidi_pkg::ACT_PUSH:
                        begin
                            if (!link_up_reg)
                            begin
                                st_next = umidi_pkg::ST_NOT_CONN;
                            end
                            else if (tx_level_reg == umidi_pkg::TX_AW'(umidi_pkg::TX_DEPTH - 1))
                            begin
                                // full: try a drain before reporting
                                st_next = umidi_pkg::ST_FULL;
                                if (!tx_busy_reg && tx_ready_drain)
                                begin
                                    tx_busy_next  = 1'b1;
                                    tx_level_next = tx_level_reg - umidi_pkg::TX_AW'(n_drain);
                                    cnt_next      = n_drain;
                                    state_next    = S_DRD;
                                end
                            end
                            else
                            begin
                                tx_we         = 1'b1;
                                tx_head_next  = umidi_pkg::tx_ptr_inc(tx_head_reg);
                                tx_level_next = tx_level_reg + umidi_pkg::TX_AW'(1);
                            end
                        end
                        umidi_pkg::ACT_POP:
                        begin
                            if (rx_level_reg == '0)
                            begin
                                st_next = umidi_pkg::ST_EMPTY;
                            end
                            else
                            begin
                                rx_re         = 1'b1;
                                rx_tail_next  = umidi_pkg::rx_ptr_inc(rx_tail_reg);
                                rx_level_next = rx_level_reg - umidi_pkg::RX_AW'(1);
                                state_next    = S_POP;
                            end
                        end
                        umidi_pkg::ACT_SERVICE:
                        begin
                            if (!tx_busy_reg && tx_ready_drain)
                            begin
                                tx_busy_next  = 1'b1;
                                tx_level_next = tx_level_reg - umidi_pkg::TX_AW'(n_drain);
                                cnt_next      = n_drain;
                                state_next    = S_DRD;
                            end
                        end
                        umidi_pkg::ACT_DONE:
                        begin
                            tx_busy_next = 1'b0;
                            if (tx_ready_drain)
                            begin
                                tx_busy_next  = 1'b1;
                                tx_level_next = tx_level_reg - umidi_pkg::TX_AW'(n_drain);
                                cnt_next      = n_drain;
                                state_next    = S_DRD;
                            end
                        end
                        umidi_pkg::ACT_RXWORD:
                        begin
                            rx_batch_ok_next = rx_ok;
                            rx_left_next     = rx_left_cur;
                            if (rx_ok && (rx_left_cur != '0))
                            begin
                                rx_we         = 1'b1;
                                rx_head_next  = umidi_pkg::rx_ptr_inc(rx_head_reg);
                                rx_level_next = rx_level_reg + umidi_pkg::RX_AW'(1);
                                rx_left_next  = rx_left_cur - umidi_pkg::CNT_W'(1);
                                if (rx_left_cur == umidi_pkg::CNT_W'(1))
                                begin
                                    rx_batch_ok_next = 1'b0;
                                end
                            end
                            else
                            begin
                                st_next = umidi_pkg::ST_NO_ROOM;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_DRD:
            begin
                tx_re        = 1'b1;
                tx_tail_next = umidi_pkg::tx_ptr_inc(tx_tail_reg);
                state_next   = S_DWAIT;
            end
            S_DWAIT:
            begin
                // read data holds in the RAM until the result register frees
                if (out_free)
                begin
                    load_res           = 1'b1;
                    result_next.kind   = umidi_pkg::KIND_WORD;
                    result_next.data   = tx_rdata;
                    result_next.status = umidi_pkg::ST_OK;
                    result_next.level  = '0;
                    result_next.last   = 1'b0;
                    cnt_next           = cnt_reg - umidi_pkg::CNT_W'(1);
                    state_next         = (cnt_reg == umidi_pkg::CNT_W'(1)) ? S_STAT : S_DRD;
                end
            end
            S_POP:
            begin
                if (out_free)
                begin
                    load_res           = 1'b1;
                    result_next.kind   = umidi_pkg::KIND_POP;
                    result_next.data   = rx_rdata;
                    result_next.status = umidi_pkg::ST_OK;
                    result_next.level  = umidi_pkg::LEVEL_W'(rx_level_reg);
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            S_STAT:
            begin
                if (out_free)
                begin
                    load_res           = 1'b1;
                    result_next.kind   = umidi_pkg::KIND_STATUS;
                    result_next.data   = '0;
                    result_next.status = st_reg;
                    result_next.level  = '0;
                    result_next.last   = 1'b1;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load_res)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            tx_level_reg     <= '0;
            rx_head_reg      <= '0;
            rx_tail_reg      <= '0;
            rx_level_reg     <= '0;
            link_up_reg      <= 1'b0;
            tx_busy_reg      <= 1'b0;
            rx_batch_ok_reg  <= 1'b0;
            rx_left_reg      <= '0;
            cnt_reg          <= '0;
            st_reg           <= umidi_pkg::ST_OK;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tx_head_reg      <= tx_head_next;
            tx_tail_reg      <= tx_tail_next;
            tx_level_reg     <= tx_level_next;
            rx_head_reg      <= rx_head_next;
            rx_tail_reg      <= rx_tail_next;
            rx_level_reg     <= rx_level_next;
            link_up_reg      <= link_up_next;
            tx_busy_reg      <= tx_busy_next;
            rx_batch_ok_reg  <= rx_batch_ok_next;
            rx_left_reg      <= rx_left_next;
            cnt_reg          <= cnt_next;
            st_reg           <= st_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_cfg_reg     <= 1'b0;
            batch_limit_reg <= umidi_pkg::BATCH_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                umidi_pkg::REG_DEV_CFG:     dev_cfg_reg     <= cfg_wdata[0];
                umidi_pkg::REG_BATCH_LIMIT: batch_limit_reg <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_nonlast_is_word: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && !result_reg.last) |-> (result_reg.kind == umidi_pkg::KIND_WORD))
        else $error("non-final result is not a sent word");

    a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRD || state_reg == S_DWAIT) |-> tx_busy_reg)
        else $error("drain in progress without transmit busy");

    a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRD || state_reg == S_DWAIT)
        |-> (cnt_reg != '0) && (cnt_reg <= umidi_pkg::CNT_W'(umidi_pkg::PACKET_WORDS)))
        else $error("drain word count out of range");

    a_rx_left_open: assert property (@(posedge clk) disable iff (!rst_n)
        (rx_left_reg != '0) |-> rx_batch_ok_reg)
        else $error("receive words pending with no open packet");
`endif

endmodule

`default_nettype wire
